@@ hw/rtl/kvfe_pkg.sv @@
// ----------------------------------------------------------------------------
// kvfe_pkg
// Shared constants, types and helpers of the key/value field extractor.
// ----------------------------------------------------------------------------
package kvfe_pkg;

   localparam int KEY_MAX     = 16;
   localparam int KEY_IDX_W   = $clog2(KEY_MAX);
   localparam int VALUE_DEPTH = 32;
   localparam int RESULT_MAX  = 32;
   localparam int COUNT_W     = $clog2(RESULT_MAX + 1);

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR  = 8'd3;

   localparam logic [7:0] EQUALS_CHAR        = 8'h3D;
   localparam logic [7:0] DEFAULT_SEPARATOR  = 8'h2C;
   localparam logic [4:0] DEFAULT_KEY_LENGTH = 5'd1;

   typedef struct packed {
      logic [8*KEY_MAX-1:0] key_chars;
      logic [4:0]           key_length;
      logic [7:0]           separator;
   } cfg_type;

   typedef struct packed {
      logic               bank;
      logic [COUNT_W-1:0] count;
      logic               found;
      logic               cut;
   } job_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

endpackage

@@ hw/rtl/kvfe_csr.sv @@
// ----------------------------------------------------------------------------
// kvfe_csr
// Configuration registers: key characters, key length and separator byte.
// ----------------------------------------------------------------------------
module kvfe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kvfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [kvfe_pkg::CSR_DATA_W-1:0]    csr_data,
   output kvfe_pkg::cfg_type                  cfg
);

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   logic [7:0]  separator_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= kvfe_pkg::DEFAULT_KEY_LENGTH;
         separator_ff  <= kvfe_pkg::DEFAULT_SEPARATOR;
      end else if (csr_valid) begin
         unique case (csr_index)
            kvfe_pkg::CSR_KEY_LOW:    key_low_ff    <= csr_data;
            kvfe_pkg::CSR_KEY_HIGH:   key_high_ff   <= csr_data;
            kvfe_pkg::CSR_KEY_LENGTH: key_length_ff <= csr_data[4:0];
            kvfe_pkg::CSR_SEPARATOR:  separator_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.key_chars  = {key_high_ff, key_low_ff};
   assign cfg.key_length = key_length_ff;
   assign cfg.separator  = separator_ff;

endmodule

@@ hw/rtl/kvfe_parser.sv @@
// ----------------------------------------------------------------------------
// kvfe_parser
// Per-byte pair parser: key match, value capture with trim and overflow flag.
// ----------------------------------------------------------------------------
module kvfe_parser #(
   parameter int VALUE_DEPTH = kvfe_pkg::VALUE_DEPTH,
   localparam int AW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1,
   localparam int CW = $clog2(VALUE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        text_byte,
   input  logic              end_of_text,
   input  kvfe_pkg::cfg_type cfg,
   output logic              wr_en,
   output logic [AW:0]       wr_addr,
   output logic [7:0]        wr_data,
   output logic              job_push,
   output kvfe_pkg::job_type job
);

   localparam logic [2:0] PH_LEAD = 3'd0;
   localparam logic [2:0] PH_KEY  = 3'd1;
   localparam logic [2:0] PH_POST = 3'd2;
   localparam logic [2:0] PH_PRE  = 3'd3;
   localparam logic [2:0] PH_VAL  = 3'd4;
   localparam logic [2:0] PH_SKIP = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   logic [2:0]    phase_ff, phase_in;
   logic [4:0]    pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] trim_ff, trim_in;
   logic          found_ff, found_in;
   logic          trunc_ff, trunc_in;
   logic          bank_ff;

   logic [4:0]    eff_len;
   logic [7:0]    b;
   logic          b_sep;
   logic          b_ws;
   logic [7:0]    key_first;
   logic [7:0]    key_cur;
   logic [4:0]    pos_next;
   logic          trim_over;
   logic          has_value;

   assign b         = text_byte;
   assign b_sep     = (b == cfg.separator);
   assign b_ws      = kvfe_pkg::is_space(b);
   assign eff_len   = (cfg.key_length > 5'(kvfe_pkg::KEY_MAX)) ?
                      5'(kvfe_pkg::KEY_MAX) : cfg.key_length;
   assign key_first = cfg.key_chars[7:0];
   assign key_cur   = cfg.key_chars[pos_ff[kvfe_pkg::KEY_IDX_W-1:0]*8 +: 8];
   assign pos_next  = 5'(pos_ff + 5'd1);

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      trim_in  = trim_ff;
      found_in = found_ff;
      trunc_in = trunc_ff;
      wr_en    = 1'b0;
      wr_addr  = {bank_ff, cnt_ff[AW-1:0]};
      wr_data  = b;
      unique case (phase_ff)
         PH_LEAD: begin
            if (!(b_sep || b_ws)) begin
               if (eff_len == 5'd0) begin
                  priority if (b == kvfe_pkg::EQUALS_CHAR) phase_in = PH_PRE;
                  else if (b_sep)                          phase_in = PH_LEAD;
                  else if (b_ws)                           phase_in = PH_POST;
                  else                                     phase_in = PH_SKIP;
               end else if (b == key_first) begin
                  if (eff_len <= 5'd1) begin
                     phase_in = PH_POST;
                  end else begin
                     phase_in = PH_KEY;
                     pos_in   = 5'd1;
                  end
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_KEY: begin
            if (b_sep) begin
               phase_in = PH_LEAD;
            end else if (b == key_cur) begin
               if (pos_next >= eff_len) begin
                  phase_in = PH_POST;
               end else begin
                  phase_in = PH_KEY;
                  pos_in   = pos_next;
               end
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_POST: begin
            priority if (b == kvfe_pkg::EQUALS_CHAR) phase_in = PH_PRE;
            else if (b_sep)                          phase_in = PH_LEAD;
            else if (b_ws)                           phase_in = PH_POST;
            else                                     phase_in = PH_SKIP;
         end
         PH_PRE, PH_VAL: begin
            if (b_sep) begin
               phase_in = (phase_ff == PH_PRE) ? PH_LEAD : PH_DONE;
            end else if ((phase_ff == PH_VAL) || !b_ws) begin
               phase_in = PH_VAL;
               found_in = 1'b1;
               if (cnt_ff < CW'(VALUE_DEPTH)) begin
                  wr_en  = accept;
                  cnt_in = CW'(cnt_ff + 1'b1);
                  if (!b_ws) trim_in = CW'(cnt_ff + 1'b1);
               end else if (!b_ws) begin
                  trunc_in = 1'b1;
               end
            end
         end
         PH_DONE: ;
         default: begin
            if (b_sep) phase_in = PH_LEAD;
         end
      endcase
   end

   // end-of-text summary
   assign trim_over = (32'(trim_in) > 32'(kvfe_pkg::RESULT_MAX));
   assign has_value = found_in && (trim_in != '0);
   assign job_push  = accept && end_of_text;
   assign job.bank  = bank_ff;
   assign job.found = has_value;
   assign job.cut   = has_value && (trunc_in || trim_over);
   assign job.count = !has_value ? kvfe_pkg::COUNT_W'(1) :
                      trim_over  ? kvfe_pkg::COUNT_W'(kvfe_pkg::RESULT_MAX) :
                                   kvfe_pkg::COUNT_W'(trim_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         trim_ff  <= '0;
         found_ff <= 1'b0;
         trunc_ff <= 1'b0;
         bank_ff  <= 1'b0;
      end else if (accept) begin
         if (end_of_text) begin
            phase_ff <= PH_LEAD;
            pos_ff   <= '0;
            cnt_ff   <= '0;
            trim_ff  <= '0;
            found_ff <= 1'b0;
            trunc_ff <= 1'b0;
            bank_ff  <= ~bank_ff;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            cnt_ff   <= cnt_in;
            trim_ff  <= trim_in;
            found_ff <= found_in;
            trunc_ff <= trunc_in;
         end
      end
   end

endmodule

@@ hw/rtl/kvfe_value_mem.sv @@
// ----------------------------------------------------------------------------
// kvfe_value_mem
// Two-bank value store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kvfe_value_mem #(
   parameter int VALUE_DEPTH = kvfe_pkg::VALUE_DEPTH,
   localparam int AW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [AW:0] wr_addr,
   input  logic [7:0]  wr_data,
   input  logic        rd_en,
   input  logic [AW:0] rd_addr,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [2**(AW+1)];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/kvfe_emitter.sv @@
// ----------------------------------------------------------------------------
// kvfe_emitter
// Reads a finished value out of the store and sends it as a run of results.
// ----------------------------------------------------------------------------
module kvfe_emitter #(
   parameter int VALUE_DEPTH = kvfe_pkg::VALUE_DEPTH,
   localparam int AW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_push,
   input  kvfe_pkg::job_type job,
   output logic              busy,
   output logic              rd_en,
   output logic [AW:0]       rd_addr,
   input  logic [7:0]        rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        value_byte,
   output logic              found,
   output logic              truncated,
   output logic              last_of_run
);

   logic                         active_ff;
   logic                         bank_ff;
   logic [kvfe_pkg::COUNT_W-1:0] idx_ff;
   logic [kvfe_pkg::COUNT_W-1:0] n_ff;
   logic                         found_ff;
   logic                         cut_ff;

   logic s1_valid_ff, s1_found_ff, s1_cut_ff, s1_last_ff;
   logic out_valid_ff, out_found_ff, out_cut_ff, out_last_ff;
   logic [7:0] out_byte_ff;

   logic                         out_free;
   logic                         s1_move;
   logic                         issue;
   logic [kvfe_pkg::COUNT_W-1:0] idx_next;
   logic                         issue_last;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && out_free;
   assign issue      = active_ff && (!s1_valid_ff || s1_move);
   assign idx_next   = kvfe_pkg::COUNT_W'(idx_ff + 1'b1);
   assign issue_last = (idx_next == n_ff);
   assign busy       = active_ff;
   assign rd_en      = issue;
   assign rd_addr    = {bank_ff, idx_ff[AW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (job_push) begin
         active_ff <= 1'b1;
      end else if (issue && issue_last) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_push) begin
         bank_ff  <= job.bank;
         n_ff     <= job.count;
         found_ff <= job.found;
         cut_ff   <= job.cut;
         idx_ff   <= '0;
      end else if (issue) begin
         idx_ff <= idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (issue) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_found_ff <= found_ff;
         s1_cut_ff   <= cut_ff;
         s1_last_ff  <= issue_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_byte_ff  <= s1_found_ff ? rd_data : 8'd0;
         out_found_ff <= s1_found_ff;
         out_cut_ff   <= s1_cut_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign value_byte  = out_byte_ff;
   assign found       = out_found_ff;
   assign truncated   = out_cut_ff;
   assign last_of_run = out_last_ff;

endmodule

@@ hw/rtl/key_value_field_extractor.sv @@
// ----------------------------------------------------------------------------
// key_value_field_extractor
// Finds the value of a configured key in a byte stream of key=value pairs.
// ----------------------------------------------------------------------------
// first result: the job is registered in the emitter, then passes its read stage and output register
// throughput: one request per cycle unless held off; one result per cycle while rsp_tready is high, up to 32 per string
// a string end is held off while the previous value still has unread bytes
// reset: synchronous, clears parse state and pipeline, config to defaults
module key_value_field_extractor #(
   parameter int VALUE_DEPTH = kvfe_pkg::VALUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: text_byte[7:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic                             req_tlast,
   // tdata: value_byte[7:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,
   // tuser: found[0], truncated[1]
   output logic [1:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kvfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kvfe_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

   kvfe_pkg::cfg_type cfg;
   kvfe_pkg::job_type job;
   logic              job_push;
   logic              emit_busy;
   logic              accept;
   logic              wr_en;
   logic [AW:0]       wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [AW:0]       rd_addr;
   logic [7:0]        rd_data;
   logic              out_found;
   logic              out_cut;

   assign req_tready = !(emit_busy && req_tlast);
   assign accept     = req_tvalid && req_tready;

   kvfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kvfe_parser #(.VALUE_DEPTH(VALUE_DEPTH)) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .cfg         (cfg),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .job_push    (job_push),
      .job         (job)
   );

   kvfe_value_mem #(.VALUE_DEPTH(VALUE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kvfe_emitter #(.VALUE_DEPTH(VALUE_DEPTH)) u_emitter (
      .clock       (clock),
      .reset       (reset),
      .job_push    (job_push),
      .job         (job),
      .busy        (emit_busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .value_byte  (rsp_tdata),
      .found       (out_found),
      .truncated   (out_cut),
      .last_of_run (rsp_tlast)
   );

   assign rsp_tuser = {out_cut, out_found};

endmodule

@@ hw/rtl/kvfe_checker.sv @@
// ----------------------------------------------------------------------------
// kvfe_checker
// Port-level checks of the key/value field extractor result channel.
// ----------------------------------------------------------------------------
module kvfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // not-found is a single zero result
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == 8'd0) && !rsp_tuser[1])
      else $error("bad not-found result");

   // within a run the found and truncated flags do not change
   a_run_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |->
         rsp_tuser == $past(rsp_tuser))
      else $error("flags changed inside a run");

endmodule

bind key_value_field_extractor kvfe_checker u_kvfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/key_value_field_extractor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_field_extractor_tb
// Feeds key=value pair strings under several key and separator settings,
// predicts the extracted value bytes and checks every response beat.
// ----------------------------------------------------------------------------
module key_value_field_extractor_tb;
   import kvfe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [2:0] {
      SCAN_LEAD, SCAN_KEY, SCAN_POST, SCAN_PRE, SCAN_VALUE, SCAN_SKIP, SCAN_DONE
   } scan_phase_t;

   typedef enum int {KEY_RANDOM, KEY_ONES, KEY_HOLDS_SEP} key_mode_t;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } text_item_t;

   typedef struct packed {
      logic [7:0] value;
      logic       found;
      logic       cut;
      logic       last;
   } value_beat_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'd0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // register shadows
   logic [8*KEY_MAX-1:0] cfg_key = '0;
   logic [4:0]           cfg_key_len = DEFAULT_KEY_LENGTH;
   logic [7:0]           cfg_sep = DEFAULT_SEPARATOR;

   // parse state of the value tracker
   scan_phase_t scan = SCAN_LEAD;
   int          key_pos = 0;
   logic [7:0]  value_store [VALUE_DEPTH];
   int          stored_count = 0;
   int          trimmed_count = 0;
   logic        value_found = 1'b0;
   logic        value_cut = 1'b0;

   value_beat_t value_bytes_due [$];
   text_item_t  text_pending [$];
   logic [7:0]  text_buf [$];

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   logic hold_rsp_request = 1'b0;
   int   hold_rsp_cycles = 0;
   int   queued_bytes = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   key_value_field_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_blank(input logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic int key_len_now();
      return (cfg_key_len > KEY_MAX) ? KEY_MAX : int'(cfg_key_len);
   endfunction

   function automatic logic [7:0] key_char_at(input int i);
      return cfg_key[(i % KEY_MAX)*8 +: 8];
   endfunction

   function automatic void after_key(input logic [7:0] b);
      if (b == EQUALS_CHAR) scan = SCAN_PRE;
      else if (b == cfg_sep) scan = SCAN_LEAD;
      else if (is_blank(b)) scan = SCAN_POST;
      else scan = SCAN_SKIP;
   endfunction

   function automatic void key_hit(input int next_pos);
      if (next_pos >= key_len_now()) begin
         scan = SCAN_POST;
      end else begin
         scan = SCAN_KEY;
         key_pos = next_pos;
      end
   endfunction

   function automatic void store_value_byte(input logic [7:0] b);
      if (stored_count < VALUE_DEPTH) begin
         value_store[stored_count] = b;
         stored_count++;
         if (!is_blank(b)) trimmed_count = stored_count;
      end else if (!is_blank(b)) begin
         value_cut = 1'b1;
      end
   endfunction

   task automatic parse_text_byte(input logic [7:0] b, input logic eot);
      value_beat_t beat;
      int n;
      case (scan)
         SCAN_LEAD: begin
            if (b != cfg_sep && !is_blank(b)) begin
               if (key_len_now() == 0) after_key(b);
               else if (b == key_char_at(0)) key_hit(1);
               else scan = SCAN_SKIP;
            end
         end
         SCAN_KEY: begin
            if (b == cfg_sep) scan = SCAN_LEAD;
            else if (b == key_char_at(key_pos)) key_hit(key_pos + 1);
            else scan = SCAN_SKIP;
         end
         SCAN_POST: after_key(b);
         SCAN_PRE: begin
            if (b == cfg_sep) begin
               scan = SCAN_LEAD;
            end else if (!is_blank(b)) begin
               scan = SCAN_VALUE;
               value_found = 1'b1;
               store_value_byte(b);
            end
         end
         SCAN_VALUE: begin
            if (b == cfg_sep) scan = SCAN_DONE;
            else store_value_byte(b);
         end
         SCAN_DONE: ;
         default: begin
            if (b == cfg_sep) scan = SCAN_LEAD;
         end
      endcase
      if (eot) begin
         if (!value_found || trimmed_count == 0) begin
            beat = '{value: 8'd0, found: 1'b0, cut: 1'b0, last: 1'b1};
            value_bytes_due.push_back(beat);
         end else begin
            n = (trimmed_count > RESULT_MAX) ? RESULT_MAX : trimmed_count;
            for (int k = 0; k < n; k++) begin
               beat.value = value_store[k];
               beat.found = 1'b1;
               beat.cut = value_cut || (trimmed_count > RESULT_MAX);
               beat.last = (k == n - 1);
               value_bytes_due.push_back(beat);
            end
         end
         scan = SCAN_LEAD;
         key_pos = 0;
         stored_count = 0;
         trimmed_count = 0;
         value_found = 1'b0;
         value_cut = 1'b0;
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic int pick_gap(input logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pick_blank();
      int r;
      r = $urandom_range(0, 6);
      return (r == 6) ? 8'd32 : 8'(9 + r);
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (is_blank(b) || b == cfg_sep || b == EQUALS_CHAR);
      return b;
   endfunction

   // request driver
   always @(negedge clock) begin
      text_item_t item;
      logic       next_valid;
      if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_fire) begin
         next_valid = 1'b0;
         if (req_fire) req_gap = pick_gap(req_calm);
         if (req_gap > 0) begin
            req_gap--;
         end else if (text_pending.size() > 0) begin
            item = text_pending.pop_front();
            req_tdata <= item.ch;
            req_tlast <= item.eot;
            next_valid = 1'b1;
         end
      end
      req_tvalid <= next_valid;
   end

   // response receiver
   always @(negedge clock) begin
      if ($urandom_range(0, 49) == 0) rsp_calm = !rsp_calm;
      if (hold_rsp_request && hold_rsp_cycles == 0) begin
         hold_rsp_cycles = 300;
         hold_rsp_request = 1'b0;
      end
      if (hold_rsp_cycles > 0) begin
         hold_rsp_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire || $urandom_range(0, 15) == 0) rsp_gap = pick_gap(rsp_calm);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      value_beat_t due;
      req_fire <= req_tvalid && req_tready && !reset;
      rsp_fire <= rsp_tvalid && rsp_tready && !reset;
      if (!reset && req_tvalid && req_tready) parse_text_byte(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (value_bytes_due.size() == 0) begin
            $error("unexpected response byte %0h", rsp_tdata);
            error_count++;
         end else begin
            due = value_bytes_due.pop_front();
            check_field("value_byte", due.value, rsp_tdata);
            check_field("found", 8'(due.found), 8'(rsp_tuser[0]));
            check_field("truncated", 8'(due.cut), 8'(rsp_tuser[1]));
            check_field("last_of_run", 8'(due.last), 8'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("key_value_field_extractor_tb: errors");
         $finish;
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_KEY_LOW:    cfg_key[63:0] = value;
         CSR_KEY_HIGH:   cfg_key[127:64] = value;
         CSR_KEY_LENGTH: cfg_key_len = value[4:0];
         CSR_SEPARATOR:  cfg_sep = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (text_pending.size() != 0 || req_tvalid || value_bytes_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic flush_text();
      text_item_t item;
      foreach (text_buf[i]) begin
         item.ch = text_buf[i];
         item.eot = (i == text_buf.size() - 1);
         text_pending.push_back(item);
      end
      queued_bytes += text_buf.size();
      text_buf = {};
   endtask

   task automatic put_blanks(input int most);
      repeat ($urandom_range(0, most)) text_buf.push_back(pick_blank());
   endtask

   // kind 6 mutates one key byte, kind 7 sends only a prefix of the key
   task automatic put_key(input int kind);
      int n, m;
      n = key_len_now();
      m = -1;
      if (kind == 7 && n > 0) n = $urandom_range(0, n - 1);
      if (kind == 6 && n > 0) m = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) text_buf.push_back((i == m) ? pick_plain() : key_char_at(i));
   endtask

   task automatic compose_pairs();
      int pairs, kind, vlen;
      pairs = $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
         if (p > 0) begin
            text_buf.push_back(cfg_sep);
            if ($urandom_range(0, 9) == 0) text_buf.push_back(cfg_sep);
         end
         kind = $urandom_range(0, 9);
         put_blanks(2);
         if (kind == 9) begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(1, 255)));
         end else begin
            put_key(kind);
            put_blanks(2);
            text_buf.push_back(EQUALS_CHAR);
            put_blanks(2);
            if (kind == 8) vlen = 0;
            else if ($urandom_range(0, 7) == 0) vlen = $urandom_range(28, 40);
            else vlen = $urandom_range(1, 8);
            for (int i = 0; i < vlen; i++) begin
               text_buf.push_back(($urandom_range(0, 9) == 0) ? pick_blank() : pick_plain());
            end
            put_blanks(4);
         end
      end
      flush_text();
   endtask

   task automatic run_phase(input logic [7:0] sep, input int key_len, input key_mode_t mode,
                            input logic hold, input int target);
      logic [8*KEY_MAX-1:0] key;
      int                   stop_at;
      wait_until_drained();
      write_register(CSR_SEPARATOR, CSR_DATA_W'(sep));
      write_register(CSR_KEY_LENGTH, CSR_DATA_W'(key_len));
      for (int i = 0; i < KEY_MAX; i++) begin
         if (mode == KEY_ONES) key[i*8 +: 8] = 8'hFF;
         else if (i < key_len) key[i*8 +: 8] = pick_plain();
         else key[i*8 +: 8] = 8'($urandom_range(0, 255));
      end
      if (mode == KEY_HOLDS_SEP) key[15:8] = sep;
      write_register(CSR_KEY_LOW, key[63:0]);
      write_register(CSR_KEY_HIGH, key[127:64]);
      if (hold) hold_rsp_request = 1'b1;
      stop_at = queued_bytes + target;
      while (queued_bytes < stop_at) compose_pairs();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default key never matches
      append_text("=");
      flush_text();
      wait_until_drained();
      write_register(CSR_KEY_LOW, 64'h6B);
      // empty value skipped, blanks around equals, trailing trim, later pair ignored
      append_text(" k =,k\t= ab \r,k=z");
      flush_text();
      append_text("kx=1,k=");
      text_buf.push_back(8'hFF);
      flush_text();

      run_phase(DEFAULT_SEPARATOR, 1, KEY_RANDOM, 1'b0, 40);
      run_phase(8'hFF, KEY_MAX, KEY_RANDOM, 1'b0, 50);
      run_phase(8'h01, $urandom_range(2, 8), KEY_RANDOM, 1'b1, 40);
      run_phase(EQUALS_CHAR, 3, KEY_ONES, 1'b0, 25);
      run_phase(8'h09, $urandom_range(9, 15), KEY_RANDOM, 1'b0, 35);
      run_phase(DEFAULT_SEPARATOR, 4, KEY_HOLDS_SEP, 1'b0, 20);

      wait_until_drained();
      if (error_count == 0) begin
         $display("key_value_field_extractor_tb: clean");
      end else begin
         $display("key_value_field_extractor_tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/kvfe_pkg.sv
hw/rtl/kvfe_csr.sv
hw/rtl/kvfe_parser.sv
hw/rtl/kvfe_value_mem.sv
hw/rtl/kvfe_emitter.sv
hw/rtl/key_value_field_extractor.sv
hw/rtl/kvfe_checker.sv
tb/key_value_field_extractor_tb.sv
